// ----- src/size_class_buffer_pool_macros.svh -----
// Assertion macros shared by the buffer pool modules.
// Needs signals clk and arst_n in the scope of each use.
`ifndef SIZE_CLASS_BUFFER_POOL_MACROS_SVH
`define SIZE_CLASS_BUFFER_POOL_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SCBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define SCBP_NEVER(lbl, cond, msg) \
	`SCBP_ASSERT(lbl, !(cond), msg)

`endif

// ----- src/scbp_pkg.sv -----
// Package for the size class buffer pool: request and response types,
// status and register codes, reset values and controller commands.
// No dependencies.
package scbp_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_FREE    = 2'd1;
	localparam logic [1:0] ST_NO_MATCH   = 2'd2;
	localparam logic [1:0] ST_NOT_IN_USE = 2'd3;

	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_SIZE_A  = 3'd0;
	localparam logic [CFG_IW-1:0] REG_COUNT_A = 3'd3;
	localparam int REG_CLASSES = 3;

	typedef struct packed {
		logic        operation;
		logic [15:0] request_size;
		logic [5:0]  buffer_handle;
	} scbp_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  granted_handle;
		logic [1:0]  class_index;
		logic [4:0]  allocated_now;
		logic [4:0]  available_now;
		logic [4:0]  peak_now;
		logic [15:0] frees_now;
		logic [15:0] misses_now;
	} scbp_rsp_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} scbp_cmd_t;

	function automatic logic [15:0] reset_size(input int unsigned c);
		logic [15:0] r;
		case (c)
			0: r = 16'd100;
			1: r = 16'd200;
			2: r = 16'd300;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] reset_count(input int unsigned c);
		logic [4:0] r;
		case (c)
			0: r = 5'd2;
			1: r = 5'd3;
			2: r = 5'd4;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/scbp_ctrl.sv -----
// Controller for the size class buffer pool: request capture and commit sequencing.
// Depends on scbp_pkg and the assertion macros header.
`include "size_class_buffer_pool_macros.svh"

module scbp_ctrl
	import scbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output scbp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.commit)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	`SCBP_ASSERT(a_commit_shows, cmd.commit |=> rsp_valid, "commit did not raise response valid")
	`SCBP_ASSERT(a_capture_execs, cmd.capture |=> (state_q == S_EXEC) && !req_ready, "capture did not start execution")
	`SCBP_NEVER(a_no_overlap, cmd.capture && cmd.commit, "capture and commit in one cycle")

endmodule

// ----- src/scbp_datapath.sv -----
// Datapath for the size class buffer pool: class registers, in-use bitmaps,
// statistics, lowest-free search and the response register.
// Depends on scbp_pkg and the assertion macros header.
`include "size_class_buffer_pool_macros.svh"

module scbp_datapath
	import scbp_pkg::*;
#(
	parameter int NUM_CLASSES = 3,
	parameter int MAX_BUFS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scbp_cmd_t         cmd,
	input  scbp_req_t         req,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [15:0]       cfg_data,
	output scbp_rsp_t         rsp
);

	localparam int CIW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int IW   = (MAX_BUFS > 1) ? $clog2(MAX_BUFS) : 1;
	localparam int CW   = $clog2(MAX_BUFS + 1);
	localparam int HRAW = $clog2(NUM_CLASSES * MAX_BUFS + 1);
	localparam int HW   = (HRAW > 6) ? HRAW : 6;

	logic [15:0]         size_q   [NUM_CLASSES];
	logic [4:0]          count_q  [NUM_CLASSES];
	logic [MAX_BUFS-1:0] map_q    [NUM_CLASSES];
	logic [CW-1:0]       alloc_q  [NUM_CLASSES];
	logic [CW-1:0]       peak_q   [NUM_CLASSES];
	logic [15:0]         frees_q  [NUM_CLASSES];
	logic [15:0]         misses_q [NUM_CLASSES];

	scbp_req_t req_s1;
	scbp_rsp_t rsp_q, rsp_d;

	logic                hit, fin, cls_ok, found, bit_set, do_stats;
	logic [CIW-1:0]      mc, fc, cls;
	logic [HW-1:0]       hnd, base;
	logic [IW-1:0]       fi, fidx;
	logic [CW-1:0]       n_eff, alloc_nx, peak_nx;
	logic [15:0]         frees_nx, misses_nx, gh, w_alloc, w_avail, w_peak, w_cls;
	logic [MAX_BUFS-1:0] map_c, map_nx, avail;

	assign hnd = HW'(req_s1.buffer_handle);

	always_comb begin
		hit  = 1'b0;
		mc   = '0;
		fc   = '0;
		base = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (size_q[c] == req_s1.request_size) begin
				hit = 1'b1;
				mc  = CIW'(c);
			end
		end
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (hnd >= HW'(c * MAX_BUFS)) begin
				fc   = CIW'(c);
				base = HW'(c * MAX_BUFS);
			end
		end
		fin = hnd < HW'(NUM_CLASSES * MAX_BUFS);
		fi  = IW'(hnd - base);
	end

	assign cls    = (req_s1.operation == OP_FREE) ? fc : mc;
	assign cls_ok = (req_s1.operation == OP_FREE) ? fin : hit;
	assign map_c  = map_q[cls];
	assign n_eff  = (8'(count_q[cls]) > 8'(MAX_BUFS)) ? CW'(MAX_BUFS) : CW'(count_q[cls]);

	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = MAX_BUFS - 1; i >= 0; i--) begin
			avail[i] = !map_c[i] && (CW'(i) < n_eff);
			if (avail[i]) begin
				found = 1'b1;
				fidx  = IW'(i);
			end
		end
	end

	assign bit_set = map_c[fi];

	always_comb begin
		map_nx    = map_c;
		alloc_nx  = alloc_q[cls];
		peak_nx   = peak_q[cls];
		frees_nx  = frees_q[cls];
		misses_nx = misses_q[cls];
		rsp_d     = '0;
		do_stats  = cls_ok;
		gh        = 16'(cls) * 16'(MAX_BUFS) + 16'(fidx);
		if (req_s1.operation == OP_ALLOC) begin
			if (!hit) begin
				rsp_d.status = ST_NO_MATCH;
			end else if (found) begin
				map_nx[fidx] = 1'b1;
				if (alloc_nx < CW'(MAX_BUFS))
					alloc_nx = alloc_nx + CW'(1);
				if (alloc_nx > peak_nx)
					peak_nx = alloc_nx;
				rsp_d.status         = ST_OK;
				rsp_d.granted_handle = gh[5:0];
			end else begin
				if (misses_nx != 16'hFFFF)
					misses_nx = misses_nx + 16'd1;
				rsp_d.status = ST_NO_FREE;
			end
		end else begin
			if (!fin || !bit_set) begin
				rsp_d.status = ST_NOT_IN_USE;
			end else begin
				map_nx[fi] = 1'b0;
				if (alloc_nx != '0)
					alloc_nx = alloc_nx - CW'(1);
				if (frees_nx != 16'hFFFF)
					frees_nx = frees_nx + 16'd1;
				rsp_d.status = ST_OK;
			end
		end
		w_cls   = 16'(cls);
		w_alloc = 16'(alloc_nx);
		w_peak  = 16'(peak_nx);
		w_avail = (n_eff > alloc_nx) ? 16'(n_eff - alloc_nx) : 16'd0;
		if (do_stats) begin
			rsp_d.class_index   = w_cls[1:0];
			rsp_d.allocated_now = w_alloc[4:0];
			rsp_d.available_now = w_avail[4:0];
			rsp_d.peak_now      = w_peak[4:0];
			rsp_d.frees_now     = frees_nx;
			rsp_d.misses_now    = misses_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_s1 <= req;
		if (cmd.commit)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				size_q[c]   <= reset_size(c);
				count_q[c]  <= reset_count(c);
				map_q[c]    <= '0;
				alloc_q[c]  <= '0;
				peak_q[c]   <= '0;
				frees_q[c]  <= '0;
				misses_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (c < REG_CLASSES && cfg_we) begin
					if (cfg_index == REG_SIZE_A + CFG_IW'(c))
						size_q[c] <= cfg_data;
					if (cfg_index == REG_COUNT_A + CFG_IW'(c))
						count_q[c] <= cfg_data[4:0];
				end
			end
			if (cmd.commit && cls_ok) begin
				map_q[cls]    <= map_nx;
				alloc_q[cls]  <= alloc_nx;
				peak_q[cls]   <= peak_nx;
				frees_q[cls]  <= frees_nx;
				misses_q[cls] <= misses_nx;
			end
		end
	end

	assign rsp = rsp_q;

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_chk
		`SCBP_ASSERT(a_alloc_matches_map, alloc_q[g] == CW'($countones(map_q[g])), "count differs from map")
		`SCBP_ASSERT(a_peak_covers, peak_q[g] >= alloc_q[g], "peak below allocated count")
		`SCBP_NEVER(a_alloc_bound, alloc_q[g] > CW'(MAX_BUFS), "allocated count above pool size")
	end

endmodule

// ----- src/size_class_buffer_pool.sv -----
// Size class buffer pool: a controller and a datapath over per-class in-use bitmaps.
// Depends on scbp_pkg, scbp_ctrl and scbp_datapath.
//
// Each request is first captured into the request register; in the execute state the
// single datapath matches the class, searches the lowest free buffer of the
// class bitmap, updates the statistics and loads the response register. The
// next request is taken while a response still waits for rsp_ready; a new
// request can finish only once the response register has been taken.
// Configuration writes on cfg_we take effect at once and are meant for idle
// periods; all bitmaps and statistics are clear after reset.

module size_class_buffer_pool
	import scbp_pkg::*;
#(
	parameter int NUM_CLASSES = 3,
	parameter int MAX_BUFS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  scbp_req_t         req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output scbp_rsp_t         rsp,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [15:0]       cfg_data
);

	scbp_cmd_t cmd;

	scbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	scbp_datapath #(
		.NUM_CLASSES (NUM_CLASSES),
		.MAX_BUFS    (MAX_BUFS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp)
	);

endmodule

// ----- verif/size_class_buffer_pool_tb.sv -----
// Testbench for size_class_buffer_pool: random and directed allocate and free requests
// checked against a scoreboard that mirrors the class bitmaps and counters.
// Depends on scbp_pkg and size_class_buffer_pool.
`timescale 1ns / 100ps

module size_class_buffer_pool_tb;
	import scbp_pkg::*;

	localparam int NCLS = 3;
	localparam int NBUF = 16;
	localparam int PERIOD = 4;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 6;
	localparam int LIMIT_CYCLES = 100000;
	localparam int PRINT_LIMIT = 100;
	localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IW-1:0] REG_SPARE_HI = 3'd7;

	class pool_scoreboard;
		logic [15:0] size_reg[NCLS];
		logic [4:0]  count_reg[NCLS];
		logic [15:0] busy_map[NCLS];
		logic [4:0]  in_use[NCLS];
		logic [4:0]  peak[NCLS];
		logic [15:0] frees[NCLS];
		logic [15:0] misses[NCLS];
		scbp_rsp_t   awaited[$];
		int errors;
		int requests;
		int responses;

		function new();
			size_reg = '{16'd100, 16'd200, 16'd300};
			count_reg = '{5'd2, 5'd3, 5'd4};
			for (int c = 0; c < NCLS; c++) begin
				busy_map[c] = '0;
				in_use[c] = '0;
				peak[c] = '0;
				frees[c] = '0;
				misses[c] = '0;
			end
			errors = 0;
			requests = 0;
			responses = 0;
		endfunction

		function int usable(int c);
			return count_reg[c] > NBUF ? NBUF : int'(count_reg[c]);
		endfunction

		function void set_register(logic [CFG_IW-1:0] idx, logic [15:0] data);
			if (idx < REG_COUNT_A)
				size_reg[idx - REG_SIZE_A] = data;
			else if (idx < REG_COUNT_A + REG_CLASSES)
				count_reg[idx - REG_COUNT_A] = data[4:0];
		endfunction

		function scbp_rsp_t with_stats(scbp_rsp_t e, int c);
			e.class_index = 2'(c);
			e.allocated_now = in_use[c];
			e.available_now = in_use[c] < usable(c) ? 5'(usable(c) - in_use[c]) : 5'd0;
			e.peak_now = peak[c];
			e.frees_now = frees[c];
			e.misses_now = misses[c];
			return e;
		endfunction

		function void note_request(scbp_req_t r);
			scbp_rsp_t e;
			int c;
			int i;
			e = '0;
			c = -1;
			i = -1;
			if (r.operation == OP_ALLOC) begin
				for (int k = NCLS - 1; k >= 0; k--)
					if (size_reg[k] == r.request_size) c = k;
				if (c < 0) begin
					e.status = ST_NO_MATCH;
				end else begin
					for (int k = usable(c) - 1; k >= 0; k--)
						if (!busy_map[c][k]) i = k;
					if (i < 0) begin
						if (misses[c] != 16'hFFFF) misses[c]++;
						e.status = ST_NO_FREE;
					end else begin
						busy_map[c][i] = 1'b1;
						if (in_use[c] < NBUF) in_use[c]++;
						if (in_use[c] > peak[c]) peak[c] = in_use[c];
						e.status = ST_OK;
						e.granted_handle = 6'(c * NBUF + i);
					end
					e = with_stats(e, c);
				end
			end else begin
				c = r.buffer_handle / NBUF;
				i = r.buffer_handle % NBUF;
				if (c >= NCLS) begin
					e.status = ST_NOT_IN_USE;
				end else if (!busy_map[c][i]) begin
					e.status = ST_NOT_IN_USE;
					e = with_stats(e, c);
				end else begin
					busy_map[c][i] = 1'b0;
					if (in_use[c] > 0) in_use[c]--;
					if (frees[c] != 16'hFFFF) frees[c]++;
					e.status = ST_OK;
					e = with_stats(e, c);
				end
			end
			awaited.push_back(e);
			requests++;
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("response %0d %s: got %0d, expected %0d",
					responses, name, got, want));
		endtask

		task check_response(scbp_rsp_t got);
			scbp_rsp_t want;
			if (awaited.size() == 0) begin
				report_mismatch("response with no request outstanding");
				return;
			end
			want = awaited.pop_front();
			responses++;
			compare_field("status", 16'(got.status), 16'(want.status));
			compare_field("granted_handle", 16'(got.granted_handle),
				16'(want.granted_handle));
			compare_field("class_index", 16'(got.class_index), 16'(want.class_index));
			compare_field("allocated_now", 16'(got.allocated_now), 16'(want.allocated_now));
			compare_field("available_now", 16'(got.available_now), 16'(want.available_now));
			compare_field("peak_now", 16'(got.peak_now), 16'(want.peak_now));
			compare_field("frees_now", got.frees_now, want.frees_now);
			compare_field("misses_now", got.misses_now, want.misses_now);
		endtask

		task close_out();
			if (awaited.size() != 0)
				report_mismatch($sformatf("%0d responses never arrived", awaited.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	scbp_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	scbp_rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	pool_scoreboard sb = new();
	bit idling = 1'b1;
	bit long_hold = 1'b0;
	int stall_left = 0;
	int cycles = 0;
	int reg_writes = 0;

	size_class_buffer_pool i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n) begin
			if (rsp_valid && rsp_ready) sb.check_response(rsp);
			if (req_valid && req_ready) sb.note_request(req);
		end
	end

	// hold off the response side in short bursts, or for one long stretch on demand
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (long_hold) begin
				long_hold = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				rsp_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	function automatic scbp_req_t make_request(logic op, logic [15:0] size, logic [5:0] handle);
		scbp_req_t r;
		r.operation = op;
		r.request_size = size;
		r.buffer_handle = handle;
		return r;
	endfunction

	function automatic scbp_req_t pick_request();
		scbp_req_t r;
		logic [5:0] held[$];
		int roll;
		r.operation = OP_ALLOC;
		r.request_size = 16'($urandom);
		r.buffer_handle = 6'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 52) begin
			if (roll < 46) r.request_size = sb.size_reg[$urandom_range(0, NCLS - 1)];
		end else begin
			r.operation = OP_FREE;
			for (int c = 0; c < NCLS; c++)
				for (int i = 0; i < NBUF; i++)
					if (sb.busy_map[c][i]) held.push_back(6'(c * NBUF + i));
			if (roll < 92 && held.size() != 0)
				r.buffer_handle = held[$urandom_range(0, held.size() - 1)];
		end
		return r;
	endfunction

	task automatic drive_request(input scbp_req_t r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
		if (idling && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	task automatic run_random(input int n);
		for (int k = 0; k < n; k++) drive_request(pick_request());
	endtask

	task automatic program_register(input logic [CFG_IW-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_register(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset sizes and counts
		drive_request(make_request(OP_ALLOC, 16'd100, 6'd0));
		drive_request(make_request(OP_ALLOC, 16'd100, 6'd63));
		drive_request(make_request(OP_ALLOC, 16'd100, 6'd0));
		drive_request(make_request(OP_ALLOC, 16'd200, 6'd0));
		drive_request(make_request(OP_ALLOC, 16'd300, 6'd0));
		drive_request(make_request(OP_ALLOC, 16'd0, 6'd63));
		drive_request(make_request(OP_ALLOC, 16'hFFFF, 6'd0));
		drive_request(make_request(OP_FREE, 16'hFFFF, 6'd1));
		drive_request(make_request(OP_FREE, 16'd0, 6'd1));
		drive_request(make_request(OP_FREE, 16'd0, 6'd47));
		drive_request(make_request(OP_FREE, 16'd0, 6'd48));
		drive_request(make_request(OP_FREE, 16'd0, 6'd63));
		drive_request(make_request(OP_FREE, 16'd0, 6'd0));
		drive_request(make_request(OP_ALLOC, 16'd100, 6'd0));
		drive_request(make_request(OP_FREE, 16'd0, 6'd16));
		drive_request(make_request(OP_FREE, 16'd0, 6'd32));
		run_random(40);
		long_hold = 1'b1;
		run_random(100);
		settle();

		// extreme sizes, duplicate size, full, oversized and empty counts
		program_register(REG_SIZE_A, 16'd0);
		program_register(CFG_IW'(REG_SIZE_A + 1), 16'hFFFF);
		program_register(CFG_IW'(REG_SIZE_A + 2), 16'd0);
		program_register(REG_COUNT_A, 16'd16);
		program_register(CFG_IW'(REG_COUNT_A + 1), 16'd31);
		program_register(CFG_IW'(REG_COUNT_A + 2), 16'd0);
		run_random(110);
		repeat (17) drive_request(make_request(OP_ALLOC, 16'd0, 6'd0));
		settle();

		// shrink class zero below the buffers still held
		program_register(REG_COUNT_A, 16'd2);
		program_register(CFG_IW'(REG_SIZE_A + 1), 16'd1);
		program_register(CFG_IW'(REG_SIZE_A + 2), 16'd2);
		program_register(CFG_IW'(REG_COUNT_A + 2), 16'hFFE5);
		program_register(REG_SPARE_LO, 16'hFFFF);
		program_register(REG_SPARE_HI, 16'hFFFF);
		drive_request(make_request(OP_ALLOC, 16'd0, 6'd0));
		drive_request(make_request(OP_FREE, 16'd0, 6'd15));
		drive_request(make_request(OP_FREE, 16'd0, 6'd14));
		drive_request(make_request(OP_ALLOC, 16'd0, 6'd0));
		drive_request(make_request(OP_FREE, 16'd0, 6'd0));
		drive_request(make_request(OP_ALLOC, 16'd0, 6'd0));
		drive_request(make_request(OP_ALLOC, 16'd2, 6'd0));
		run_random(100);
		settle();

		for (int p = 0; p < 2; p++) begin
			for (int c = 0; c < NCLS; c++) begin
				program_register(CFG_IW'(REG_SIZE_A + c),
					$urandom_range(0, 1) ? 16'($urandom_range(0, 5)) : 16'($urandom));
				program_register(CFG_IW'(REG_COUNT_A + c),
					{11'($urandom), 5'($urandom_range(0, 31))});
			end
			if (p == 0) begin
				run_random(60);
			end else begin
				run_random(10);
				idling = 1'b0;
				run_random(50);
			end
			settle();
		end

		sb.close_out();
		$display("summary: %0d requests, %0d responses checked, %0d register writes",
			sb.requests, sb.responses, reg_writes);
		$display("summary: exhaustion, unmatched sizes, bad handles, shrunk and oversized pools");
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
